/* design/lfpid_pkg.sv */
// Shared types and constants for the line follower PID controller.
`default_nettype none
package lfpid_pkg;

  localparam int SensorCount = 8;
  localparam int SumWidth    = 16;
  localparam int CntWidth    = $clog2(SensorCount + 1);
  localparam int CenterLo    = SensorCount / 2 - 1;

  localparam logic [7:0]  PivotDuty  = 8'd150;
  localparam logic [7:0]  SearchDuty = 8'd80;
  localparam logic [7:0]  CoastDuty  = 8'd45;
  localparam logic [31:0] PivotLimit = 32'd900;
  localparam logic [31:0] SearchLimit = 32'd450;
  localparam logic [31:0] CooldownMs = 32'd450;
  localparam logic [31:0] CoastMs    = 32'd250;
  localparam logic signed [6:0] CornerError = -7'sd40;

  typedef enum logic [2:0] {
    MODE_FOLLOW = 3'd0,
    MODE_WIDE   = 3'd1,
    MODE_COAST  = 3'd2,
    MODE_PIVOT  = 3'd3,
    MODE_SEARCH = 3'd4,
    MODE_DONE   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_PROP   = 3'd0,
    REG_INTEG  = 3'd1,
    REG_DERIV  = 3'd2,
    REG_CRUISE = 3'd3,
    REG_CEIL   = 3'd4,
    REG_FCLAMP = 3'd5,
    REG_WSPEED = 3'd6,
    REG_WCLAMP = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DECIDE,
    ST_MAC,
    ST_WHEEL,
    ST_OUT
  } seq_e;

  // One multiply-accumulate request for the shared unit.
  typedef struct packed {
    logic               clear;
    logic               enable;
    logic signed [12:0] coef;
    logic signed [SumWidth:0] operand;
  } mac_req_t;

endpackage
`default_nettype wire

/* design/lfpid_mac.sv */
// Shared signed multiply-accumulate unit, one product per cycle.
`default_nettype none
module lfpid_mac (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lfpid_pkg::mac_req_t     req_i,
  output logic signed [47:0]           acc_o
);
  import lfpid_pkg::*;

  logic signed [47:0] acc_q, acc_d;
  logic signed [30:0] prod;

  assign prod = 31'(req_i.coef * req_i.operand);

  always_comb begin
    acc_d = acc_q;
    if (req_i.clear) begin
      acc_d = '0;
    end else if (req_i.enable) begin
      acc_d = acc_q + 48'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

/* design/lfpid_div.sv */
// Restoring divider for the mean sensor weight, one quotient bit per cycle.
`default_nettype none
module lfpid_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [10:0]                       dividend_i,
  input  wire logic [lfpid_pkg::CntWidth-1:0]    divisor_i,
  output logic                                   done_o,
  output logic [10:0]                            quot_o
);
  import lfpid_pkg::*;

  localparam int Bits = 11;

  logic [Bits-1:0]   quot_q, quot_d;
  logic [CntWidth:0] rem_q, rem_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [CntWidth:0] trial;

  assign trial = {rem_q[CntWidth-1:0], quot_q[Bits-1]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 4'(Bits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d  = trial - {1'b0, divisor_i};
        quot_d = {quot_q[Bits-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[Bits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign done_o = !busy_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

/* design/line_follower_pid_controller.sv */
// Top level of the line follower PID controller.
// Usage:
//   s_axis carries one sensor sample per transfer:
//     tdata[7:0] sensor_bits, tdata[39:8] now_ms.
//   m_axis returns one result per sample:
//     tdata[7:0] right fwd, [15:8] right rev, [23:16] left fwd,
//     [31:24] left rev, [34:32] drive_mode, [41:35] line_error.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the gain and speed registers;
//   write only while no sample is in flight.
// Steps: one scan step per sensor, the divider (11 quotient bits, then the
// done step), one decision step, then two multiply steps in wide mode or
// three in follow mode on the shared multiply-accumulate unit, one wheel
// step and one output step. Coast, pivot, search and stop results go from
// the decision step straight to the output step. The block takes one sample
// at a time; s_axis_tready is low from accept until the result register has
// been handed over, so no new sample is taken before the last result has
// gone. The sensor scan and the divider take most of the time per sample.
// Reset: all mode and PID state clears, registers take their defaults.
// A stalled receiver holds the result in the output register and keeps the
// input side stalled until it is taken.
`default_nettype none
module line_follower_pid_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // sensor_bits, now_ms
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // rf, rr, lf, lr, drive_mode, line_error
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i
);
  import lfpid_pkg::*;

  // Configuration registers.
  logic [11:0] prop_q, integ_q, deriv_q;
  logic [7:0]  cruise_q, ceil_q, fclamp_q, wspeed_q, wclamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q   <= 12'd720;
      integ_q  <= 12'd0;
      deriv_q  <= 12'd64;
      cruise_q <= 8'd60;
      ceil_q   <= 8'd130;
      fclamp_q <= 8'd70;
      wspeed_q <= 8'd40;
      wclamp_q <= 8'd55;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PROP:   prop_q   <= cfg_data_i;
        REG_INTEG:  integ_q  <= cfg_data_i;
        REG_DERIV:  deriv_q  <= cfg_data_i;
        REG_CRUISE: cruise_q <= cfg_data_i[7:0];
        REG_CEIL:   ceil_q   <= cfg_data_i[7:0];
        REG_FCLAMP: fclamp_q <= cfg_data_i[7:0];
        REG_WSPEED: wspeed_q <= cfg_data_i[7:0];
        REG_WCLAMP: wclamp_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Controller state.
  mode_e             mode_q, mode_d;
  logic signed [6:0] prev_q, prev_d;
  logic signed [SumWidth-1:0] sum_q, sum_d;
  logic [31:0]       tend_q, tend_d, jtime_q, jtime_d, mstart_q, mstart_d;
  logic              jact_q, jact_d, sdir_q, sdir_d;
  logic [2:0]        hits_q, hits_d;

  // Sample and sequencer.
  seq_e              st_q, st_d;
  logic [SensorCount-1:0] bits_q, bits_d;
  logic [31:0]       now_q, now_d;
  logic [CntWidth-1:0] idx_q, idx_d, bc_q, bc_d, lc_q, lc_d, cc_q, cc_d, rc_q, rc_d;
  logic signed [10:0] wsum_q, wsum_d;
  logic signed [6:0] e_q, e_d;
  logic [1:0]        mstep_q, mstep_d;
  logic              wide_q, wide_d;
  logic [47:0]       out_q, out_d;
  logic              ovalid_q, ovalid_d;

  // Divider: started on the last scan step with the completed weight sum
  // and sensor count.
  logic        div_start, div_done;
  logic [10:0] div_quot, wabs;
  assign wabs = wsum_d[10] ? 11'(-wsum_d) : 11'(wsum_d);

  lfpid_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(wabs),
    .divisor_i(bc_d), .done_o(div_done), .quot_o(div_quot)
  );

  // Multiply-accumulate unit.
  mac_req_t          mreq;
  logic signed [47:0] acc;
  lfpid_mac u_mac (.clk_i, .rst_ni, .req_i(mreq), .acc_o(acc));

  // Combinational helpers.
  logic [31:0] d_pivot, d_search, d_turn, d_junc;
  logic        cooldown;
  logic signed [SumWidth:0] sum_ext;
  logic signed [SumWidth-1:0] sum_sat;
  logic signed [47:0] lim, corr, base, lsum, rsum;
  logic [7:0]  lduty, rduty;
  logic signed [11:0] equo;

  assign d_pivot  = now_q - mstart_q;
  assign d_turn   = now_q - tend_q;
  assign d_junc   = now_q - jtime_q;
  assign d_search = d_pivot;
  assign cooldown = d_turn < CooldownMs;

  assign sum_ext = {sum_q[SumWidth-1], sum_q} + (SumWidth+1)'(e_q);
  always_comb begin
    if (sum_ext[SumWidth] != sum_ext[SumWidth-1]) begin
      sum_sat = sum_ext[SumWidth] ? {1'b1, {(SumWidth-1){1'b0}}}
                                  : {1'b0, {(SumWidth-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SumWidth-1:0];
    end
  end

  assign lim  = wide_q ? 48'(wclamp_q) <<< 8 : 48'(fclamp_q) <<< 8;
  assign corr = (acc > lim) ? lim : ((acc < -lim) ? -lim : acc);
  assign base = wide_q ? 48'(wspeed_q) <<< 8 : 48'(cruise_q) <<< 8;
  assign lsum = base + corr;
  assign rsum = base - corr;

  function automatic logic [7:0] wheel(input logic signed [47:0] v, input logic [7:0] ceil);
    logic [39:0] q;
    q = 40'(v >>> 8);
    if (v < 0) return 8'd0;
    return (q > 40'(ceil)) ? ceil : q[7:0];
  endfunction

  assign lduty = wheel(lsum, ceil_q);
  assign rduty = wheel(rsum, ceil_q);
  assign equo  = wsum_q[10] ? -12'(div_quot) : 12'(div_quot);

  function automatic logic [47:0] pack(input logic [7:0] rf, input logic [7:0] rr,
                                       input logic [7:0] lf, input logic [7:0] lr,
                                       input mode_e m, input logic [6:0] e);
    return {6'd0, e, m, lr, lf, rr, rf};
  endfunction

  always_comb begin
    st_d = st_q; bits_d = bits_q; now_d = now_q; idx_d = idx_q;
    bc_d = bc_q; lc_d = lc_q; cc_d = cc_q; rc_d = rc_q; wsum_d = wsum_q;
    e_d = e_q; mstep_d = mstep_q; wide_d = wide_q; out_d = out_q;
    ovalid_d = ovalid_q;
    mode_d = mode_q; prev_d = prev_q; sum_d = sum_q; tend_d = tend_q;
    jtime_d = jtime_q; mstart_d = mstart_q; jact_d = jact_q;
    sdir_d = sdir_q; hits_d = hits_q;
    div_start = 1'b0;
    mreq = '0;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid && !ovalid_q) begin
          bits_d = s_axis_tdata[SensorCount-1:0];
          now_d  = s_axis_tdata[39:8];
          idx_d = '0; bc_d = '0; lc_d = '0; cc_d = '0; rc_d = '0; wsum_d = '0;
          st_d = ST_SCAN;
        end
      end
      // Scan one sensor per cycle.
      ST_SCAN: begin
        if (bits_q[idx_q[$clog2(SensorCount)-1:0]]) begin
          bc_d = bc_q + 1'b1;
          wsum_d = wsum_q + 11'((2 * int'(idx_q) - (SensorCount - 1)) * 8);
          if (int'(idx_q) < CenterLo) lc_d = lc_q + 1'b1;
          else if (int'(idx_q) <= CenterLo + 1) cc_d = cc_q + 1'b1;
          else rc_d = rc_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (int'(idx_q) == SensorCount - 1) begin
          st_d = ST_DIV;
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (bc_q == '0) e_d = '0;
          else if (equo > 12'sd63) e_d = 7'sd63;
          else if (equo < -12'sd64) e_d = -7'sd64;
          else e_d = equo[6:0];
          st_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        st_d = ST_OUT;
        if (mode_q == MODE_PIVOT) begin
          if (d_pivot >= PivotLimit) begin
            mode_d = MODE_FOLLOW; tend_d = now_q;
            out_d = pack(0, 0, 0, 0, MODE_DONE, e_q);
          end else begin
            hits_d = (cc_q != '0) ? hits_q + 3'd1 : 3'd0;
            if (hits_d >= 3'd4) begin
              mode_d = MODE_FOLLOW; tend_d = now_q;
              out_d = pack(0, 0, 0, 0, MODE_DONE, e_q);
            end else begin
              out_d = pack(PivotDuty, 0, 0, PivotDuty, MODE_PIVOT, e_q);
            end
          end
        end else if (mode_q == MODE_SEARCH) begin
          if (d_search >= SearchLimit || bits_q != '0) begin
            mode_d = MODE_FOLLOW;
            out_d = pack(0, 0, 0, 0, MODE_DONE, e_q);
          end else if (sdir_q) begin
            out_d = pack(0, SearchDuty, SearchDuty, 0, MODE_SEARCH, e_q);
          end else begin
            out_d = pack(SearchDuty, 0, 0, SearchDuty, MODE_SEARCH, e_q);
          end
        end else begin
          mode_d = MODE_FOLLOW;
          if (!cooldown && cc_q == '0 && lc_q >= 2 && rc_q == '0) begin
            mode_d = MODE_PIVOT; mstart_d = now_q; hits_d = '0;
            sum_d = '0; prev_d = CornerError;
            out_d = pack(PivotDuty, 0, 0, PivotDuty, MODE_PIVOT, e_q);
          end else if (int'(bc_q) >= SensorCount - 2) begin
            if (cc_q != '0) begin
              wide_d = 1'b1; mstep_d = '0; st_d = ST_MAC;
              mreq.clear = 1'b1;
            end else begin
              if (!jact_q) begin
                jact_d = 1'b1; jtime_d = now_q;
              end
              if (jact_q && d_junc > CoastMs && !cooldown) begin
                jact_d = 1'b0;
                mode_d = MODE_PIVOT; mstart_d = now_q; hits_d = '0;
                out_d = pack(PivotDuty, 0, 0, PivotDuty, MODE_PIVOT, e_q);
              end else begin
                out_d = pack(CoastDuty, 0, CoastDuty, 0, MODE_COAST, e_q);
              end
            end
          end else begin
            jact_d = 1'b0;
            if (bits_q == '0) begin
              mode_d = MODE_SEARCH; mstart_d = now_q;
              sdir_d = !prev_q[6];
              if (!prev_q[6]) out_d = pack(0, SearchDuty, SearchDuty, 0, MODE_SEARCH, e_q);
              else out_d = pack(SearchDuty, 0, 0, SearchDuty, MODE_SEARCH, e_q);
            end else begin
              wide_d = 1'b0; mstep_d = '0; st_d = ST_MAC;
              sum_d = sum_sat;
              mreq.clear = 1'b1;
            end
          end
        end
      end
      // Accumulate Kp*e, Kd*(e-prev), then Ki*sum in follow mode.
      ST_MAC: begin
        mreq.enable = 1'b1;
        mstep_d = mstep_q + 2'd1;
        case (mstep_q)
          2'd0: begin
            mreq.coef = {1'b0, prop_q};
            mreq.operand = (SumWidth+1)'(e_q);
          end
          2'd1: begin
            mreq.coef = {1'b0, deriv_q};
            mreq.operand = (SumWidth+1)'(e_q) - (SumWidth+1)'(prev_q);
            if (wide_q) st_d = ST_WHEEL;
          end
          default: begin
            mreq.coef = {1'b0, integ_q};
            mreq.operand = (SumWidth+1)'(sum_q);
            st_d = ST_WHEEL;
          end
        endcase
      end
      ST_WHEEL: begin
        prev_d = e_q;
        out_d = pack(rduty, 0, lduty, 0, wide_q ? MODE_WIDE : MODE_FOLLOW, e_q);
        st_d = ST_OUT;
      end
      ST_OUT: begin
        ovalid_d = 1'b1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; mode_q <= MODE_FOLLOW; prev_q <= '0; sum_q <= '0;
      tend_q <= '0; jtime_q <= '0; mstart_q <= '0; jact_q <= 1'b0;
      sdir_q <= 1'b0; hits_q <= '0; ovalid_q <= 1'b0;
      idx_q <= '0; bc_q <= '0; lc_q <= '0; cc_q <= '0; rc_q <= '0;
      wsum_q <= '0; mstep_q <= '0; wide_q <= 1'b0;
    end else begin
      st_q <= st_d; mode_q <= mode_d; prev_q <= prev_d; sum_q <= sum_d;
      tend_q <= tend_d; jtime_q <= jtime_d; mstart_q <= mstart_d;
      jact_q <= jact_d; sdir_q <= sdir_d; hits_q <= hits_d;
      ovalid_q <= ovalid_d; idx_q <= idx_d; bc_q <= bc_d; lc_q <= lc_d;
      cc_q <= cc_d; rc_q <= rc_d; wsum_q <= wsum_d; mstep_q <= mstep_d;
      wide_q <= wide_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d; now_q <= now_d; e_q <= e_d; out_q <= out_d;
  end

  assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

/* design/lfpid_checker.sv */
// Port-level checks for the line follower PID controller.
`default_nettype none
module lfpid_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  a_no_ready_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open while result held");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept while busy");
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[34:32] <= 3'd5) else $error("bad mode");
endmodule

bind line_follower_pid_controller lfpid_checker u_lfpid_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

/* dv/tb_line_follower_pid_controller.sv */
// Testbench for the line follower PID controller: a scoreboard predicts each sample's result.
`default_nettype none

// Tracks the controller state and holds the predicted results in order.
class lfpid_scoreboard;
  logic [11:0] prop_gain, integ_gain, deriv_gain;
  logic [7:0]  cruise_speed, duty_ceiling, follow_clamp, wide_speed, wide_lim;
  lfpid_pkg::mode_e mode_q;
  int          prev_err;
  longint      err_sum;
  logic [31:0] turn_end, junc_time, man_start;
  bit          junc_active, dir_right;
  int unsigned hits;
  logic [47:0] pending[$];
  int          errors;

  function new();
    prop_gain = 720; integ_gain = 0; deriv_gain = 64;
    cruise_speed = 60; duty_ceiling = 130; follow_clamp = 70;
    wide_speed = 40; wide_lim = 55;
    mode_q = lfpid_pkg::MODE_FOLLOW;
    prev_err = 0; err_sum = 0;
    turn_end = '0; junc_time = '0; man_start = '0;
    junc_active = 0; dir_right = 0; hits = 0;
    errors = 0;
  endfunction

  function void write_reg(lfpid_pkg::reg_idx_e idx, logic [11:0] val);
    case (idx)
      lfpid_pkg::REG_PROP:   prop_gain = val;
      lfpid_pkg::REG_INTEG:  integ_gain = val;
      lfpid_pkg::REG_DERIV:  deriv_gain = val;
      lfpid_pkg::REG_CRUISE: cruise_speed = val[7:0];
      lfpid_pkg::REG_CEIL:   duty_ceiling = val[7:0];
      lfpid_pkg::REG_FCLAMP: follow_clamp = val[7:0];
      lfpid_pkg::REG_WSPEED: wide_speed = val[7:0];
      default:               wide_lim = val[7:0];
    endcase
  endfunction

  function logic [7:0] duty(longint v);
    longint q;
    if (v < 0) return 8'd0;
    q = v >>> 8;
    return (q > duty_ceiling) ? duty_ceiling : q[7:0];
  endfunction

  function longint limit(longint c, logic [7:0] lim);
    longint m;
    m = longint'(lim) * 256;
    if (c > m) return m;
    if (c < -m) return -m;
    return c;
  endfunction

  function void push(logic [7:0] rf, rr, lf, lr, lfpid_pkg::mode_e m, int e);
    logic [6:0] e7;
    e7 = e[6:0];
    pending.push_back({e7, m, lr, lf, rr, rf});
  endfunction

  // Predict one sample's result.
  function void note_sample(logic [7:0] bits, logic [31:0] now);
    int lc, cc, rc, bc, wsum, e;
    longint c, base;
    bit cool;
    lc = 0; cc = 0; rc = 0; bc = 0; wsum = 0; e = 0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        bc++;
        wsum += (2 * i - 7) * 8;
        if (i < 3) lc++;
        else if (i <= 4) cc++;
        else rc++;
      end
    end
    if (bc > 0) e = wsum / bc;
    if (mode_q == lfpid_pkg::MODE_PIVOT) begin
      if (now - man_start >= 32'd900) begin
        mode_q = lfpid_pkg::MODE_FOLLOW; turn_end = now;
        push(0, 0, 0, 0, lfpid_pkg::MODE_DONE, e); return;
      end
      hits = (cc > 0) ? ((hits + 1) & 7) : 0;
      if (hits >= 4) begin
        mode_q = lfpid_pkg::MODE_FOLLOW; turn_end = now;
        push(0, 0, 0, 0, lfpid_pkg::MODE_DONE, e); return;
      end
      push(150, 0, 0, 150, lfpid_pkg::MODE_PIVOT, e); return;
    end
    if (mode_q == lfpid_pkg::MODE_SEARCH) begin
      if (now - man_start >= 32'd450 || bits != 0) begin
        mode_q = lfpid_pkg::MODE_FOLLOW;
        push(0, 0, 0, 0, lfpid_pkg::MODE_DONE, e); return;
      end
      if (dir_right) push(0, 80, 80, 0, lfpid_pkg::MODE_SEARCH, e);
      else push(80, 0, 0, 80, lfpid_pkg::MODE_SEARCH, e);
      return;
    end
    mode_q = lfpid_pkg::MODE_FOLLOW;
    cool = (now - turn_end) < 32'd450;
    if (!cool && cc == 0 && lc >= 2 && rc == 0) begin
      mode_q = lfpid_pkg::MODE_PIVOT; man_start = now; hits = 0;
      err_sum = 0; prev_err = -40;
      push(150, 0, 0, 150, lfpid_pkg::MODE_PIVOT, e); return;
    end
    if (bc >= 6) begin
      if (cc > 0) begin
        c = longint'(prop_gain) * e + longint'(deriv_gain) * (e - prev_err);
        base = longint'(wide_speed) * 256;
        c = limit(c, wide_lim);
        prev_err = e;
        push(duty(base - c), 0, duty(base + c), 0, lfpid_pkg::MODE_WIDE, e); return;
      end
      if (!junc_active) begin
        junc_active = 1; junc_time = now;
      end
      if ((now - junc_time) > 32'd250 && !cool) begin
        junc_active = 0;
        mode_q = lfpid_pkg::MODE_PIVOT; man_start = now; hits = 0;
        push(150, 0, 0, 150, lfpid_pkg::MODE_PIVOT, e); return;
      end
      push(45, 0, 45, 0, lfpid_pkg::MODE_COAST, e); return;
    end
    junc_active = 0;
    if (bits == 0) begin
      mode_q = lfpid_pkg::MODE_SEARCH; man_start = now; dir_right = (prev_err >= 0);
      if (dir_right) push(0, 80, 80, 0, lfpid_pkg::MODE_SEARCH, e);
      else push(80, 0, 0, 80, lfpid_pkg::MODE_SEARCH, e);
      return;
    end
    err_sum += e;
    if (err_sum > 32767) err_sum = 32767;
    if (err_sum < -32768) err_sum = -32768;
    c = longint'(prop_gain) * e + longint'(integ_gain) * err_sum
        + longint'(deriv_gain) * (e - prev_err);
    c = limit(c, follow_clamp);
    prev_err = e;
    push(duty(cruise_speed * 256 - c), 0, duty(cruise_speed * 256 + c), 0,
         lfpid_pkg::MODE_FOLLOW, e);
  endfunction

  function void check_result(logic [47:0] got);
    logic [47:0] exp_r;
    if (pending.size() == 0) begin
      $error("result %h with no prediction waiting", got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got[7:0] !== exp_r[7:0]) begin
      $error("right_fwd_duty exp %0d got %0d", exp_r[7:0], got[7:0]); errors++;
    end
    if (got[15:8] !== exp_r[15:8]) begin
      $error("right_rev_duty exp %0d got %0d", exp_r[15:8], got[15:8]); errors++;
    end
    if (got[23:16] !== exp_r[23:16]) begin
      $error("left_fwd_duty exp %0d got %0d", exp_r[23:16], got[23:16]); errors++;
    end
    if (got[31:24] !== exp_r[31:24]) begin
      $error("left_rev_duty exp %0d got %0d", exp_r[31:24], got[31:24]); errors++;
    end
    if (got[34:32] !== exp_r[34:32]) begin
      $error("drive_mode exp %0d got %0d", exp_r[34:32], got[34:32]); errors++;
    end
    if (got[41:35] !== exp_r[41:35]) begin
      $error("line_error exp %0d got %0d", $signed(exp_r[41:35]), $signed(got[41:35]));
      errors++;
    end
  endfunction
endclass

module tb_line_follower_pid_controller;
  import lfpid_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int          DrainCycles = 60;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [11:0] cfg_data_i;

  lfpid_scoreboard sb;
  logic [31:0] clock_ms;  // sample timestamp, advanced per sample
  bit          hold_off;  // receiver holds off while set
  int unsigned cycles;

  line_follower_pid_controller i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort the run if it hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: randomly stall; hold fully while hold_off is set.
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= !hold_off && ($urandom_range(0, 3) != 0 || cycles[10]);
    end
  end

  // Offer one sample and wait for the transfer; optional gap beforehand.
  // tvalid stays high after the transfer until a gap or a drain drops it.
  task automatic send_sample(logic [7:0] bits, int unsigned dt);
    int g;
    g = cycles[9] ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    clock_ms = clock_ms + dt;
    s_axis_tdata  <= {clock_ms, bits};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(bits, clock_ms);
  endtask

  // Wait until every predicted result has come, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write one register; the caller drops the write enable after the last one.
  task automatic write_cfg(reg_idx_e idx, logic [11:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Random line-like sample: contiguous run of black sensors, with some noise.
  function automatic logic [7:0] line_bits();
    int w, p;
    w = $urandom_range(1, 3);
    p = $urandom_range(0, 8 - w);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return (8'((1 << w) - 1)) << p;
  endfunction

  // Run a random phase; shapes cover follow, pivots, junctions and searches.
  task automatic random_phase(int n);
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          repeat (10) send_sample(line_bits(), $urandom_range(1, 20));
          k += 10;
        end
        2: begin  // left corner then pivot until center
          send_sample(8'h07, 500);
          repeat (6) send_sample($urandom_range(0, 1) ? 8'h18 : 8'h03,
                                 $urandom_range(10, 200));
          k += 7;
        end
        3: begin  // junction: coast then pivot
          repeat (6) send_sample($urandom_range(0, 1) ? 8'hE7 : 8'hFF,
                                 $urandom_range(40, 150));
          k += 6;
        end
        4: begin  // line lost: search
          repeat (5) send_sample($urandom_range(0, 4) == 0 ? line_bits() : 8'h00,
                                 $urandom_range(20, 200));
          k += 5;
        end
        default: begin
          send_sample(8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000));
          k += 1;
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    hold_off = 0;
    clock_ms = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we_i = 0;
    cfg_idx_i = REG_PROP;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: cooldown right after reset, extremes, each mode.
    send_sample(8'h07, 10);      // left corner during cooldown
    send_sample(8'h01, 10);
    send_sample(8'h80, 10);
    send_sample(8'h18, 10);
    send_sample(8'hFF, 10);      // wide
    send_sample(8'hE7, 10);      // junction coast
    send_sample(8'hE7, 500);     // junction pivot after cooldown
    send_sample(8'h18, 10);
    send_sample(8'h18, 10);
    send_sample(8'h18, 10);
    send_sample(8'h18, 10);      // fourth center hit ends pivot
    send_sample(8'h00, 500);     // search
    send_sample(8'h00, 100);
    send_sample(8'h00, 400);     // search times out
    send_sample(8'h07, 600);     // left corner pivot
    send_sample(8'h00, 950);     // pivot times out
    send_sample(8'h00, 32'hFFFF_FF00);  // timestamp wrap
    send_sample(8'h81, 10);
    send_sample(8'hC0, 10);
    send_sample(8'h00, 10);
    drain();

    // Hold the receiver off while samples keep coming.
    hold_off = 1;
    fork
      random_phase(20);
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
    join
    drain();

    // Sweep register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 8; r++) begin
        logic [11:0] v;
        case (ph)
          0: v = 12'hFFF;
          1: v = 12'h000;
          2: v = (r < 3) ? 12'h010 : 12'h0FF;
          default: v = (r < 3) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 255));
        endcase
        write_cfg(reg_idx_e'(r), v);
      end
      cfg_we_i <= 0;
      random_phase(200);
      drain();
    end

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

/* line_follower_pid_controller.f */
design/lfpid_pkg.sv
design/lfpid_mac.sv
design/lfpid_div.sv
design/line_follower_pid_controller.sv
design/lfpid_checker.sv
dv/tb_line_follower_pid_controller.sv
